[sv/fuvg_pkg.sv]
// fuvg_pkg: shared types and constants for the field unit vector and gyrofrequency block
package fuvg_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned SUM_W = 64;
  localparam int unsigned UNIT_SHIFT = 30;
  localparam int unsigned ROOT_STEPS = 32;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_LANES = 4;
  localparam int unsigned GYRO_LANE = 3;

  localparam logic [0:0] REG_ELECTRON_MASS = 1'b0;
  localparam logic [0:0] REG_MAGNETIZED_THRESHOLD = 1'b1;
  localparam logic [DATA_W-1:0] MASS_RESET = 32'h0001_0000;
  localparam logic [DATA_W-1:0] THRESHOLD_RESET = 32'h0000_0001;

  typedef struct packed {
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] field_z;
  } field_t;

  typedef struct packed {
    logic [31:0]        magnitude;
    logic signed [31:0] unit_x;
    logic signed [31:0] unit_y;
    logic signed [31:0] unit_z;
    logic [31:0]        gyrofrequency;
    logic               magnetized;
    logic               mass_error;
  } result_t;

  // component magnitudes and signs riding along the square root
  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
  } comp_t;

  // per-word flags riding along the dividers
  typedef struct packed {
    logic [31:0] magnitude;
    logic [2:0]  neg;
    logic        magnetized;
    logic        mass_error;
    logic        overflow;
  } side_t;

endpackage

[sv/fuvg_sq.sv]
// fuvg_sq: absolute values, squares and sum of squares, three register stages
module fuvg_sq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          valid_in,
  input  fuvg_pkg::field_t              din,
  output logic                          valid_out,
  output logic [fuvg_pkg::SUM_W-1:0]    sum,
  output fuvg_pkg::comp_t               comp
);

  logic [2:0][31:0] field_in;
  logic [2:0][31:0] abs_next;
  logic [2:0]       neg_next;

  logic             v1, v2, v3;
  logic [2:0][31:0] abs1;
  logic [2:0]       neg1;
  logic [2:0][63:0] sq2;
  fuvg_pkg::comp_t  comp2;
  logic [63:0]      sum3;
  fuvg_pkg::comp_t  comp3;

  assign field_in[0] = din.field_x;
  assign field_in[1] = din.field_y;
  assign field_in[2] = din.field_z;

  always_comb begin
    for (int h = 0; h < 3; h++) begin
      neg_next[h] = field_in[h][31];
      abs_next[h] = field_in[h][31] ? 32'(~field_in[h] + 32'd1) : field_in[h];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= valid_in;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abs1 <= abs_next;
      neg1 <= neg_next;
      for (int h = 0; h < 3; h++) begin
        sq2[h] <= {32'd0, abs1[h]} * {32'd0, abs1[h]};
      end
      comp2.mag <= abs1;
      comp2.neg <= neg1;
      // three squares of at most 2^62 each, the sum fits 64 bits
      sum3  <= sq2[0] + sq2[1] + sq2[2];
      comp3 <= comp2;
    end
  end

  assign valid_out = v3;
  assign sum       = sum3;
  assign comp      = comp3;

endmodule

[sv/fuvg_isqrt.sv]
// fuvg_isqrt: pipelined integer square root, one root bit per stage
module fuvg_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          valid_in,
  input  logic [fuvg_pkg::SUM_W-1:0]    sum,
  input  fuvg_pkg::comp_t               tag_in,
  output logic                          valid_out,
  output logic [31:0]                   root,
  output fuvg_pkg::comp_t               tag_out
);

  localparam int unsigned N = fuvg_pkg::ROOT_STEPS;

  logic [63:0]     rem_s  [0:N];
  logic [31:0]     root_s [0:N];
  logic            vld_s  [0:N];
  fuvg_pkg::comp_t tag_s  [0:N];

  assign rem_s[0]  = sum;
  assign root_s[0] = 32'd0;
  assign vld_s[0]  = valid_in;
  assign tag_s[0]  = tag_in;

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam int K = N - 1 - i;
    logic [64:0] trial;
    logic        take;

    // rem holds s - root^2; trial is (root + 2^k)^2 - root^2
    assign trial = ({33'd0, root_s[i]} << (K + 1)) + (65'd1 << (2 * K));
    assign take  = {1'b0, rem_s[i]} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[i+1] <= 1'b0;
      end else if (en) begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_s[i+1] <= tag_s[i];
        if (take) begin
          rem_s[i+1]  <= rem_s[i] - trial[63:0];
          root_s[i+1] <= root_s[i] | (32'd1 << K);
        end else begin
          rem_s[i+1]  <= rem_s[i];
          root_s[i+1] <= root_s[i];
        end
      end
    end
  end

  assign valid_out = vld_s[N];
  assign root      = root_s[N];
  assign tag_out   = tag_s[N];

endmodule

[sv/fuvg_div.sv]
// fuvg_div: four-lane pipelined restoring divider, one quotient bit per stage
module fuvg_div (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      en,
  input  logic                                      valid_in,
  input  logic [fuvg_pkg::DIV_LANES-1:0][31:0]      rem_init,
  input  logic [fuvg_pkg::DIV_LANES-1:0][31:0]      num_low,
  input  logic [fuvg_pkg::DIV_LANES-1:0][31:0]      divisor,
  input  fuvg_pkg::side_t                           tag_in,
  output logic                                      valid_out,
  output logic [fuvg_pkg::DIV_LANES-1:0][31:0]      quot,
  output fuvg_pkg::side_t                           tag_out
);

  localparam int unsigned N = fuvg_pkg::DIV_STEPS;
  localparam int unsigned L = fuvg_pkg::DIV_LANES;

  logic [L-1:0][31:0] r_s [0:N];
  logic [L-1:0][31:0] n_s [0:N];
  logic [L-1:0][31:0] d_s [0:N];
  logic [L-1:0][31:0] q_s [0:N];
  logic               vld_s [0:N];
  fuvg_pkg::side_t    tag_s [0:N];

  assign r_s[0]   = rem_init;
  assign n_s[0]   = num_low;
  assign d_s[0]   = divisor;
  assign q_s[0]   = '0;
  assign vld_s[0] = valid_in;
  assign tag_s[0] = tag_in;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [L-1:0][31:0] r_next;
    logic [L-1:0][31:0] q_next;

    always_comb begin
      logic [32:0] r2;
      logic        ge;
      for (int l = 0; l < L; l++) begin
        r2 = {r_s[i][l], n_s[i][l][31]};
        ge = r2 >= {1'b0, d_s[i][l]};
        r_next[l] = ge ? 32'(r2 - {1'b0, d_s[i][l]}) : r2[31:0];
        q_next[l] = {q_s[i][l][30:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[i+1] <= 1'b0;
      end else if (en) begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_s[i+1]   <= r_next;
        q_s[i+1]   <= q_next;
        d_s[i+1]   <= d_s[i];
        tag_s[i+1] <= tag_s[i];
        for (int l = 0; l < L; l++) begin
          n_s[i+1][l] <= {n_s[i][l][30:0], 1'b0};
        end
      end
    end
  end

  assign valid_out = vld_s[N];
  assign quot      = q_s[N];
  assign tag_out   = tag_s[N];

endmodule

[sv/field_unit_vector_and_gyrofrequency_unit.sv]
// field_unit_vector_and_gyrofrequency_unit: top level, register port and result assembly
//
// Takes one signed Q16.16 field vector per word and returns its magnitude
// floor(sqrt(x^2+y^2+z^2)), the unit vector in Q1.30 rounded to nearest with
// ties away from zero, and the gyrofrequency magnitude/electron_mass,
// saturated at all ones. A magnitude of zero or below magnetized_threshold
// gives a zero unit vector and frequency; a zero mass sets mass_error and
// zeroes the frequency. The pipeline takes one word per clock unless the
// output stalls. Its stages are squaring and summing, the square root (one
// root bit per stage), the division setup, the four parallel dividers (one
// quotient bit per stage) and an output register.
// A stall at the output holds the whole pipeline. Registers: electron_mass
// at byte address 0, magnetized_threshold at 4; write them only while idle.
module field_unit_vector_and_gyrofrequency_unit #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fuvg_pkg::field_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fuvg_pkg::result_t               out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fuvg_pkg::ADDR_W-1:0]     paddr,
  input  logic [fuvg_pkg::DATA_W-1:0]     pwdata,
  output logic [fuvg_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);

  logic [31:0] electron_mass;
  logic [31:0] magnetized_threshold;
  logic        en;

  logic            sq_valid;
  logic [63:0]     sq_sum;
  fuvg_pkg::comp_t sq_comp;

  logic            rt_valid;
  logic [31:0]     rt_root;
  fuvg_pkg::comp_t rt_comp;

  logic                                 prep_valid;
  logic [fuvg_pkg::DIV_LANES-1:0][31:0] prep_rem;
  logic [fuvg_pkg::DIV_LANES-1:0][31:0] prep_low;
  logic [fuvg_pkg::DIV_LANES-1:0][31:0] prep_div;
  fuvg_pkg::side_t                      prep_side;

  logic [fuvg_pkg::DIV_LANES-1:0][31:0] rem_next;
  logic [fuvg_pkg::DIV_LANES-1:0][31:0] low_next;
  logic [fuvg_pkg::DIV_LANES-1:0][31:0] div_next;
  fuvg_pkg::side_t                      side_next;

  logic                                 dv_valid;
  logic [fuvg_pkg::DIV_LANES-1:0][31:0] dv_quot;
  fuvg_pkg::side_t                      dv_side;

  fuvg_pkg::result_t res_next;
  logic              out_valid_r;
  fuvg_pkg::result_t out_data_r;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      electron_mass        <= fuvg_pkg::MASS_RESET;
      magnetized_threshold <= fuvg_pkg::THRESHOLD_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2:2])
        fuvg_pkg::REG_ELECTRON_MASS:        electron_mass        <= pwdata;
        fuvg_pkg::REG_MAGNETIZED_THRESHOLD: magnetized_threshold <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2:2])
      fuvg_pkg::REG_ELECTRON_MASS:        prdata = electron_mass;
      fuvg_pkg::REG_MAGNETIZED_THRESHOLD: prdata = magnetized_threshold;
      default:                            prdata = '0;
    endcase
  end

  // whole pipeline advances unless a result is waiting unread
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  fuvg_sq u_sq (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (in_valid),
    .din       (in_data),
    .valid_out (sq_valid),
    .sum       (sq_sum),
    .comp      (sq_comp)
  );

  fuvg_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (sq_valid),
    .sum       (sq_sum),
    .tag_in    (sq_comp),
    .valid_out (rt_valid),
    .root      (rt_root),
    .tag_out   (rt_comp)
  );

  // division setup: each numerator split into top and low words; in the unit lanes the top part is below the divisor
  always_comb begin
    logic [63:0] num;
    for (int h = 0; h < 3; h++) begin
      num = ({32'd0, rt_comp.mag[h]} << fuvg_pkg::UNIT_SHIFT) + {33'd0, rt_root[31:1]};
      rem_next[h] = num[63:32];
      low_next[h] = num[31:0];
      div_next[h] = rt_root;
    end
    num = {32'd0, rt_root} << FRACTION_BITS;
    rem_next[fuvg_pkg::GYRO_LANE] = num[63:32];
    low_next[fuvg_pkg::GYRO_LANE] = num[31:0];
    div_next[fuvg_pkg::GYRO_LANE] = electron_mass;

    side_next.magnitude  = rt_root;
    side_next.neg        = rt_comp.neg;
    side_next.magnetized = (rt_root != 32'd0) && (rt_root >= magnetized_threshold);
    side_next.mass_error = electron_mass == 32'd0;
    // quotient needs more than 32 bits when the top part reaches the mass
    side_next.overflow   = num[63:32] >= electron_mass;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (en) begin
      prep_valid <= rt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_rem  <= rem_next;
      prep_low  <= low_next;
      prep_div  <= div_next;
      prep_side <= side_next;
    end
  end

  fuvg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (prep_valid),
    .rem_init  (prep_rem),
    .num_low   (prep_low),
    .divisor   (prep_div),
    .tag_in    (prep_side),
    .valid_out (dv_valid),
    .quot      (dv_quot),
    .tag_out   (dv_side)
  );

  always_comb begin
    logic [2:0][31:0] unit;
    for (int h = 0; h < 3; h++) begin
      if (!dv_side.magnetized) begin
        unit[h] = 32'd0;
      end else if (dv_side.neg[h]) begin
        unit[h] = 32'(~dv_quot[h] + 32'd1);
      end else begin
        unit[h] = dv_quot[h];
      end
    end
    res_next.magnitude  = dv_side.magnitude;
    res_next.unit_x     = unit[0];
    res_next.unit_y     = unit[1];
    res_next.unit_z     = unit[2];
    if (!dv_side.magnetized || dv_side.mass_error) begin
      res_next.gyrofrequency = 32'd0;
    end else if (dv_side.overflow) begin
      res_next.gyrofrequency = '1;
    end else begin
      res_next.gyrofrequency = dv_quot[fuvg_pkg::GYRO_LANE];
    end
    res_next.magnetized = dv_side.magnetized;
    res_next.mass_error = dv_side.mass_error;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res_next;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[test/field_unit_vector_and_gyrofrequency_unit_test.sv]
// testbench for the field unit vector and gyrofrequency unit: directed and random field words
`timescale 1ns / 100ps

module field_unit_vector_and_gyrofrequency_unit_test;

  localparam int FRAC = 16;
  localparam int LATENCY = 69;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  fuvg_pkg::field_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fuvg_pkg::result_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [fuvg_pkg::ADDR_W-1:0] paddr = '0;
  logic [fuvg_pkg::DATA_W-1:0] pwdata = '0;
  logic [fuvg_pkg::DATA_W-1:0] prdata;
  logic pready;

  // own copy of the registers
  logic [31:0] mass_reg;
  logic [31:0] thresh_reg;

  fuvg_pkg::result_t pending_results[$];
  int errors = 0;
  bit calm = 1'b0;

  field_unit_vector_and_gyrofrequency_unit #(.FRACTION_BITS(FRAC)) i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] s);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic fuvg_pkg::result_t normalize_field(input fuvg_pkg::field_t f);
    fuvg_pkg::result_t res;
    logic [63:0] a[3];
    logic ng[3];
    logic [63:0] sum;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] fr;
    logic [31:0] c[3];
    logic mz;
    c[0] = f.field_x;
    c[1] = f.field_y;
    c[2] = f.field_z;
    sum = 0;
    for (int h = 0; h < 3; h++) begin
      ng[h] = c[h][31];
      a[h] = ng[h] ? 64'h1_0000_0000 - {32'd0, c[h]} : {32'd0, c[h]};
      sum += a[h] * a[h];
    end
    m = int_sqrt(sum) & 64'hFFFF_FFFF;
    mz = (m != 0) && (m >= thresh_reg);
    res = '0;
    res.magnitude = m[31:0];
    for (int h = 0; h < 3; h++) begin
      q = 0;
      if (mz) begin
        q = ((a[h] << 30) + (m >> 1)) / m;
        if (ng[h]) q = (64'h1_0000_0000 - q) & 64'hFFFF_FFFF;
      end
      if (h == 0) res.unit_x = q[31:0];
      else if (h == 1) res.unit_y = q[31:0];
      else res.unit_z = q[31:0];
    end
    if (mz && mass_reg != 0) begin
      fr = (m << FRAC) / mass_reg;
      res.gyrofrequency = (fr > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : fr[31:0];
    end
    res.magnetized = mz;
    res.mass_error = (mass_reg == 0);
    return res;
  endfunction

  // result checker and output stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected word %h", $realtime, out_data);
          errors++;
        end else begin
          fuvg_pkg::result_t e;
          e = pending_results.pop_front();
          if (e.magnitude !== out_data.magnitude)
            $display("%0t magnitude exp %h got %h", $realtime, e.magnitude,
                     out_data.magnitude);
          if (e.unit_x !== out_data.unit_x)
            $display("%0t unit_x exp %h got %h", $realtime, e.unit_x, out_data.unit_x);
          if (e.unit_y !== out_data.unit_y)
            $display("%0t unit_y exp %h got %h", $realtime, e.unit_y, out_data.unit_y);
          if (e.unit_z !== out_data.unit_z)
            $display("%0t unit_z exp %h got %h", $realtime, e.unit_z, out_data.unit_z);
          if (e.gyrofrequency !== out_data.gyrofrequency)
            $display("%0t gyrofrequency exp %h got %h", $realtime, e.gyrofrequency,
                     out_data.gyrofrequency);
          if (e.magnetized !== out_data.magnetized)
            $display("%0t magnetized exp %b got %b", $realtime, e.magnetized,
                     out_data.magnetized);
          if (e.mass_error !== out_data.mass_error)
            $display("%0t mass_error exp %b got %b", $realtime, e.mass_error,
                     out_data.mass_error);
          if (e !== out_data) errors++;
        end
      end
    end
    out_ready <= calm || ($urandom_range(99) >= 17);
  end

  // valid stays high from one word to the next unless an idle cycle is drawn
  task automatic send_field(input fuvg_pkg::field_t f);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= f;
    pending_results.push_back(normalize_field(f));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= fuvg_pkg::ADDR_W'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == fuvg_pkg::REG_ELECTRON_MASS) mass_reg = val;
    else thresh_reg = val;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic fuvg_pkg::field_t rand_field;
    fuvg_pkg::field_t f;
    int k;
    k = $urandom_range(3);
    f.field_x = $urandom;
    f.field_y = $urandom;
    f.field_z = $urandom;
    // often shrink so the unmagnetized and small-magnitude cases show up
    if (k == 1) begin
      f.field_x >>>= $urandom_range(31);
      f.field_y >>>= $urandom_range(31);
      f.field_z >>>= $urandom_range(31);
    end else if (k == 2) begin
      f.field_x = $signed(f.field_x) >>> 28;
      f.field_y = $signed(f.field_y) >>> 28;
      f.field_z = $signed(f.field_z) >>> 28;
    end
    return f;
  endfunction

  task automatic test_extremes;
    logic [31:0] v[6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1,
                          32'hFFFF_FFFF, 32'h0001_0000};
    for (int i = 0; i < 6; i++) send_field('{v[i], v[(i + 1) % 6], v[(i + 3) % 6]});
    send_field('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_field('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_field('0);
    send_field('{32'h0, 32'h0, 32'hFFFF_FFFF});
    drain();
  endtask

  task automatic test_zero_mass;
    write_reg(fuvg_pkg::REG_ELECTRON_MASS, 32'h0);
    write_reg(fuvg_pkg::REG_MAGNETIZED_THRESHOLD, 32'h0);
    send_field('0);
    send_field('{32'h0003_0000, 32'h0004_0000, 32'h0});
    send_field('{32'hFFFF_FFFF, 32'h0, 32'h0});
    drain();
  endtask

  task automatic test_overflow;
    write_reg(fuvg_pkg::REG_ELECTRON_MASS, 32'h1);
    write_reg(fuvg_pkg::REG_MAGNETIZED_THRESHOLD, 32'hFFFF_FFFF);
    send_field('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_field('{32'h0000_0100, 32'h0, 32'h0});
    drain();
    write_reg(fuvg_pkg::REG_MAGNETIZED_THRESHOLD, 32'h1);
    send_field('{32'h0000_0100, 32'h0, 32'h0});
    send_field('{32'h7FFF_FFFF, 32'h0, 32'h0});
    drain();
  endtask

  task automatic test_random_phase(input logic [31:0] mass, input logic [31:0] thr,
                                   input int count);
    write_reg(fuvg_pkg::REG_ELECTRON_MASS, mass);
    write_reg(fuvg_pkg::REG_MAGNETIZED_THRESHOLD, thr);
    for (int i = 0; i < count; i++) send_field(rand_field());
    drain();
  endtask

  initial begin
    mass_reg = fuvg_pkg::MASS_RESET;
    thresh_reg = fuvg_pkg::THRESHOLD_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_zero_mass();
    test_overflow();
    test_random_phase(32'h0001_0000, 32'h1, 300);
    test_random_phase(32'hFFFF_FFFF, 32'h0, 250);
    test_random_phase($urandom, $urandom >> $urandom_range(31), 250);
    test_random_phase(32'h0, 32'h0001_0000, 150);
    calm = 1'b1;
    test_random_phase($urandom_range(255, 1), $urandom >> 8, 300);
    calm = 1'b0;
    test_random_phase($urandom, 32'h0000_8000, 250);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/fuvg_pkg.sv
sv/fuvg_sq.sv
sv/fuvg_isqrt.sv
sv/fuvg_div.sv
sv/field_unit_vector_and_gyrofrequency_unit.sv
test/field_unit_vector_and_gyrofrequency_unit_test.sv
